// File: rtl/sfu_pkg.sv
`timescale 1ns / 1ps

package sfu_pkg;

    // Number format and field widths
    localparam int FRAC_BITS  = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CFG_W      = 31;
    localparam int CMD_W      = 3;
    localparam int IDX_W      = 3;
    localparam int DIFF_W     = DATA_WIDTH + 1;

    // Normaliser sizing: magnitudes are brought below 2^NB before squaring
    localparam int NB       = 30;
    localparam int SUM_W    = 2 * NB + 1;
    localparam int ROOT_W   = NB + 1;
    localparam int SQ_STEPS = NB + 1;
    localparam int QW       = FRAC_BITS + 1;
    localparam int UW       = FRAC_BITS + 2;
    localparam int REM_W    = ROOT_W + 1;

    // Pipeline depths
    localparam int NORM_LAT = 4 + SQ_STEPS + QW;
    localparam int SFU_LAT  = 2 * NORM_LAT + 10;

    // Modes
    localparam logic [CMD_W-1:0] CMD_SEEK      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FLEE      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INTERCEPT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PURSUIT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_EVADE     = 3'd4;

    // Register map
    localparam logic [IDX_W-1:0] CFG_MAX_SPEED     = 3'd0;
    localparam logic [IDX_W-1:0] CFG_SEEK_GAIN     = 3'd1;
    localparam logic [IDX_W-1:0] CFG_FLEE_GAIN     = 3'd2;
    localparam logic [IDX_W-1:0] CFG_FLEE_RADIUS   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_LOOKAHEAD     = 3'd4;
    localparam logic [IDX_W-1:0] CFG_PURSUE_RADIUS = 3'd5;

    localparam logic [CFG_W-1:0] RST_MAX_SPEED     = 31'd6553600;
    localparam logic [CFG_W-1:0] RST_SEEK_GAIN     = 31'd65536;
    localparam logic [CFG_W-1:0] RST_FLEE_GAIN     = 31'd65536;
    localparam logic [CFG_W-1:0] RST_FLEE_RADIUS   = 31'd6553600;
    localparam logic [CFG_W-1:0] RST_LOOKAHEAD     = 31'd65536;
    localparam logic [CFG_W-1:0] RST_PURSUE_RADIUS = 31'd3276800;

    typedef logic signed [DATA_WIDTH-1:0] t_word;

    // Per-item context carried alongside the arithmetic
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        t_word            ax;
        t_word            ay;
        t_word            vx;
        t_word            vy;
        t_word            tx;
        t_word            ty;
        t_word            px;
        t_word            py;
        logic             eng;
    } t_ctx;

    // Sign-extend by one bit for exact differences
    function automatic logic signed [DIFF_W-1:0] sx1(input t_word v);
        return $signed({v[DATA_WIDTH-1], v});
    endfunction

    // Sign-extend by two bits for sums that are saturated afterwards
    function automatic logic signed [DATA_WIDTH+1:0] sx2(input t_word v);
        return $signed({{2{v[DATA_WIDTH-1]}}, v});
    endfunction

    // Saturate a widened value to the word range
    function automatic t_word sat_word(input logic signed [DATA_WIDTH+1:0] v);
        logic signed [DATA_WIDTH+1:0] hi;
        logic signed [DATA_WIDTH+1:0] lo;
        hi = $signed({3'b000, {(DATA_WIDTH-1){1'b1}}});
        lo = $signed({3'b111, {(DATA_WIDTH-1){1'b0}}});
        if (v > hi) begin
            return hi[DATA_WIDTH-1:0];
        end else if (v < lo) begin
            return lo[DATA_WIDTH-1:0];
        end
        return v[DATA_WIDTH-1:0];
    endfunction

endpackage

// File: rtl/sfu_mulq.sv
`timescale 1ns / 1ps

module sfu_mulq (
    input  logic                       i_clk,
    input  sfu_pkg::t_word             i_a,
    input  logic [sfu_pkg::CFG_W-1:0]  i_b,
    output sfu_pkg::t_word             o_p
);
    import sfu_pkg::*;

    localparam int PROD_W = DATA_WIDTH + CFG_W;
    localparam int SHR_W  = PROD_W - FRAC_BITS;

    logic [DATA_WIDTH-1:0] neg_a;
    logic [DATA_WIDTH-1:0] mag_a;
    logic [PROD_W-1:0]     n_prod;
    logic [PROD_W-1:0]     r_prod;
    logic                  n_neg;
    logic                  r_neg;
    logic [SHR_W-1:0]      shr;
    logic [SHR_W-1:0]      lim;
    logic [DATA_WIDTH-1:0] low;

    // Multiply magnitudes, keep the sign aside
    always_comb begin
        neg_a  = -i_a;
        n_neg  = i_a[DATA_WIDTH-1];
        mag_a  = n_neg ? neg_a : i_a;
        n_prod = {{CFG_W{1'b0}}, mag_a} * {{DATA_WIDTH{1'b0}}, i_b};
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_neg  <= n_neg;
    end

    // Drop the fraction, then reapply the sign with saturation
    always_comb begin
        shr = r_prod[PROD_W-1:FRAC_BITS];
        lim = SHR_W'(1) << (DATA_WIDTH - 1);
        low = shr[DATA_WIDTH-1:0];
        if (!r_neg) begin
            o_p = (shr >= lim) ? $signed({1'b0, {(DATA_WIDTH-1){1'b1}}}) : $signed(low);
        end else begin
            o_p = (shr > lim) ? $signed({1'b1, {(DATA_WIDTH-1){1'b0}}}) : $signed(-low);
        end
    end

endmodule

// File: rtl/sfu_norm.sv
`timescale 1ns / 1ps

module sfu_norm (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic signed [sfu_pkg::DIFF_W-1:0]  i_dx,
    input  logic signed [sfu_pkg::DIFF_W-1:0]  i_dy,
    input  sfu_pkg::t_ctx                      i_ctx,
    output logic                               o_valid,
    output logic signed [sfu_pkg::UW-1:0]      o_ux,
    output logic signed [sfu_pkg::UW-1:0]      o_uy,
    output sfu_pkg::t_ctx                      o_ctx
);
    import sfu_pkg::*;

    typedef struct packed {
        logic            v;
        logic            sx;
        logic            sy;
        logic [NB-1:0]   mx;
        logic [NB-1:0]   my;
        logic [SUM_W-1:0] rem;
        logic [SUM_W:0]  res;
        t_ctx            ctx;
    } t_sq;

    typedef struct packed {
        logic              v;
        logic              sx;
        logic              sy;
        logic [ROOT_W-1:0] len;
        logic [REM_W-1:0]  rx;
        logic [REM_W-1:0]  ry;
        logic [QW-1:0]     qx;
        logic [QW-1:0]     qy;
        t_ctx              ctx;
    } t_dv;

    // One step of the digit-by-digit square root
    function automatic t_sq sq_step(input t_sq s, input int k);
        logic [SUM_W:0] bitv;
        logic [SUM_W:0] trial;
        t_sq o;
        o     = s;
        bitv  = (SUM_W+1)'(1) << (2 * (NB - k));
        trial = s.res + bitv;
        if ({1'b0, s.rem} >= trial) begin
            o.rem = SUM_W'({1'b0, s.rem} - trial);
            o.res = (s.res >> 1) + bitv;
        end else begin
            o.res = s.res >> 1;
        end
        return o;
    endfunction

    // One quotient bit of each restoring divider
    function automatic t_dv dv_step(input t_dv d, input logic fbx, input logic fby);
        logic [REM_W-1:0] shx;
        logic [REM_W-1:0] shy;
        logic [REM_W-1:0] den;
        t_dv o;
        o   = d;
        den = {1'b0, d.len};
        shx = {d.rx[REM_W-2:0], fbx};
        shy = {d.ry[REM_W-2:0], fby};
        if (shx >= den) begin
            o.rx = shx - den;
            o.qx = {d.qx[QW-2:0], 1'b1};
        end else begin
            o.rx = shx;
            o.qx = {d.qx[QW-2:0], 1'b0};
        end
        if (shy >= den) begin
            o.ry = shy - den;
            o.qy = {d.qy[QW-2:0], 1'b1};
        end else begin
            o.ry = shy;
            o.qy = {d.qy[QW-2:0], 1'b0};
        end
        return o;
    endfunction

    // Front stages
    logic            r_a_v, r_a_sx, r_a_sy;
    logic [NB-1:0]   r_a_mx, r_a_my, n_a_mx, n_a_my;
    t_ctx            r_a_ctx;
    logic            r_b_v, r_b_sx, r_b_sy;
    logic [NB-1:0]   r_b_mx, r_b_my;
    logic [2*NB-1:0] r_b_qx, r_b_qy;
    t_ctx            r_b_ctx;
    t_sq             r_c, n_c;
    t_sq             r_sq [SQ_STEPS];
    t_sq             n_sq [SQ_STEPS];
    t_dv             r_dv [QW];
    t_dv             n_dv [QW];
    t_dv             dv_seed;
    logic            r_o_v;
    logic signed [UW-1:0] r_o_ux, r_o_uy, n_o_ux, n_o_uy;
    t_ctx            r_o_ctx;

    logic [DIFF_W-1:0]     neg_x, neg_y;
    logic [DATA_WIDTH-1:0] mag_x, mag_y, mag_or;

    // Take magnitudes and shift both down until they fit the squarer
    always_comb begin
        int sh;
        neg_x  = -i_dx;
        neg_y  = -i_dy;
        mag_x  = i_dx[DIFF_W-1] ? neg_x[DATA_WIDTH-1:0] : i_dx[DATA_WIDTH-1:0];
        mag_y  = i_dy[DIFF_W-1] ? neg_y[DATA_WIDTH-1:0] : i_dy[DATA_WIDTH-1:0];
        mag_or = mag_x | mag_y;
        sh     = 0;
        for (int i = NB; i < DATA_WIDTH; i++) begin
            if (mag_or[i]) begin
                sh = i - NB + 1;
            end
        end
        n_a_mx = NB'(mag_x >> sh);
        n_a_my = NB'(mag_y >> sh);
    end

    // Sum of squares seeds the root
    always_comb begin
        n_c.v   = r_b_v;
        n_c.sx  = r_b_sx;
        n_c.sy  = r_b_sy;
        n_c.mx  = r_b_mx;
        n_c.my  = r_b_my;
        n_c.rem = {1'b0, r_b_qx} + {1'b0, r_b_qy};
        n_c.res = '0;
        n_c.ctx = r_b_ctx;
    end

    // Root stages
    always_comb begin
        n_sq[0] = sq_step(r_c, 0);
        for (int k = 1; k < SQ_STEPS; k++) begin
            n_sq[k] = sq_step(r_sq[k-1], k);
        end
    end

    // Divider stages: numerator is the magnitude shifted up by the fraction
    always_comb begin
        dv_seed.v   = r_sq[SQ_STEPS-1].v;
        dv_seed.sx  = r_sq[SQ_STEPS-1].sx;
        dv_seed.sy  = r_sq[SQ_STEPS-1].sy;
        dv_seed.len = r_sq[SQ_STEPS-1].res[ROOT_W-1:0];
        dv_seed.rx  = REM_W'(r_sq[SQ_STEPS-1].mx >> 1);
        dv_seed.ry  = REM_W'(r_sq[SQ_STEPS-1].my >> 1);
        dv_seed.qx  = '0;
        dv_seed.qy  = '0;
        dv_seed.ctx = r_sq[SQ_STEPS-1].ctx;
        n_dv[0] = dv_step(dv_seed, r_sq[SQ_STEPS-1].mx[0], r_sq[SQ_STEPS-1].my[0]);
        for (int i = 1; i < QW; i++) begin
            n_dv[i] = dv_step(r_dv[i-1], 1'b0, 1'b0);
        end
    end

    // Reapply signs; a zero length gives a zero vector
    always_comb begin
        if (r_dv[QW-1].len == '0) begin
            n_o_ux = '0;
            n_o_uy = '0;
        end else begin
            n_o_ux = r_dv[QW-1].sx ? -$signed({1'b0, r_dv[QW-1].qx})
                                   :  $signed({1'b0, r_dv[QW-1].qx});
            n_o_uy = r_dv[QW-1].sy ? -$signed({1'b0, r_dv[QW-1].qy})
                                   :  $signed({1'b0, r_dv[QW-1].qy});
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_o_v <= r_dv[QW-1].v;
        end
    end

    // Advance the stage payloads
    always_ff @(posedge i_clk) begin
        r_a_sx  <= i_dx[DIFF_W-1];
        r_a_sy  <= i_dy[DIFF_W-1];
        r_a_mx  <= n_a_mx;
        r_a_my  <= n_a_my;
        r_a_ctx <= i_ctx;
        r_b_sx  <= r_a_sx;
        r_b_sy  <= r_a_sy;
        r_b_mx  <= r_a_mx;
        r_b_my  <= r_a_my;
        r_b_qx  <= {{NB{1'b0}}, r_a_mx} * {{NB{1'b0}}, r_a_mx};
        r_b_qy  <= {{NB{1'b0}}, r_a_my} * {{NB{1'b0}}, r_a_my};
        r_b_ctx <= r_a_ctx;
        r_o_ux  <= n_o_ux;
        r_o_uy  <= n_o_uy;
        r_o_ctx <= r_dv[QW-1].ctx;
    end

    // Root and divider stages, valid flags cleared on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.v <= 1'b0;
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_sq[k].v <= 1'b0;
            end
            for (int i = 0; i < QW; i++) begin
                r_dv[i].v <= 1'b0;
            end
        end else begin
            r_c <= n_c;
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_sq[k] <= n_sq[k];
            end
            for (int i = 0; i < QW; i++) begin
                r_dv[i] <= n_dv[i];
            end
        end
    end

    assign o_valid = r_o_v;
    assign o_ux    = r_o_ux;
    assign o_uy    = r_o_uy;
    assign o_ctx   = r_o_ctx;

endmodule

// File: rtl/steering_force_unit.sv
`timescale 1ns / 1ps

// Steering force unit.
// Issue a command by holding start high for one cycle with the mode and the
// agent and target beats on the inputs; busy stays low, so a new beat can be
// issued on every clock. Each accepted beat yields one result: o_valid pulses
// for one cycle with o_force_x, o_force_y and o_engaged, in issue order.
// Throughput is one beat per cycle. The depth is set by two normalisers in
// series (each a 31-step square root followed by a 17-step divider), framed
// by the fixed-point multiply and saturate stages. Configuration writes
// (i_cfg_we, i_cfg_idx, i_cfg_data) are registered and take effect on beats
// issued after the pipeline has drained. Synchronous reset clears all valid
// bits and restores the register defaults; beats in flight are dropped. The
// receiver cannot stall: every result is presented for exactly one cycle.
module steering_force_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [sfu_pkg::CMD_W-1:0]  i_cmd,
    input  sfu_pkg::t_word             i_agent_pos_x,
    input  sfu_pkg::t_word             i_agent_pos_y,
    input  sfu_pkg::t_word             i_agent_vel_x,
    input  sfu_pkg::t_word             i_agent_vel_y,
    input  sfu_pkg::t_word             i_target_pos_x,
    input  sfu_pkg::t_word             i_target_pos_y,
    input  sfu_pkg::t_word             i_target_vel_x,
    input  sfu_pkg::t_word             i_target_vel_y,
    input  logic                       i_cfg_we,
    input  logic [sfu_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [sfu_pkg::CFG_W-1:0]  i_cfg_data,
    output logic                       o_valid,
    output sfu_pkg::t_word             o_force_x,
    output sfu_pkg::t_word             o_force_y,
    output logic                       o_engaged
);
    import sfu_pkg::*;

    localparam logic signed [UW-1:0] UNIT_POS = UW'(1) << FRAC_BITS;
    localparam logic signed [UW-1:0] UNIT_NEG = -UNIT_POS;

    logic [CFG_W-1:0] r_max_speed, r_seek_gain, r_flee_gain;
    logic [CFG_W-1:0] r_flee_radius, r_lookahead, r_pursue_radius;

    logic   r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v, r9_v;
    t_ctx   r1_ctx, r2_ctx, r3_ctx, n3_ctx, r4_ctx, r5_ctx, n5_ctx;
    t_ctx   r6_ctx, n6_ctx, r7_ctx, r8_ctx, r9_ctx;
    t_word  r1_wx, r1_wy;
    t_word  la_x, la_y, pur_x, pur_y, spd_x, spd_y, g_x, g_y;
    t_word  r8_dx, r8_dy, n8_dx, n8_dy;

    logic   na_v, nb_v;
    logic signed [UW-1:0] na_ux, na_uy, nb_ux, nb_uy;
    t_ctx   na_ctx, nb_ctx;

    logic [CFG_W-1:0]   r4_mtx, r4_mty, r4_mpx, r4_mpy;
    logic               r4_okt, r4_okp, r5_okt, r5_okp;
    logic [2*CFG_W-1:0] r5_sqtx, r5_sqty, r5_sqpx, r5_sqpy, r5_rr;
    logic [DIFF_W-1:0]  dtx, dty, dpx, dpy;
    logic [DIFF_W-1:0]  ntx, nty, npx, npy;
    logic [DATA_WIDTH-1:0] mtx, mty, mpx, mpy;
    logic [DATA_WIDTH-1:0] rad_ext;
    logic               wt, wp, away8;
    logic [CFG_W-1:0]   gain8;
    logic               r_out_v, r_eng;
    t_word              r_fx, r_fy;

    assign busy = 1'b0;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed     <= RST_MAX_SPEED;
            r_seek_gain     <= RST_SEEK_GAIN;
            r_flee_gain     <= RST_FLEE_GAIN;
            r_flee_radius   <= RST_FLEE_RADIUS;
            r_lookahead     <= RST_LOOKAHEAD;
            r_pursue_radius <= RST_PURSUE_RADIUS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_SPEED:     r_max_speed     <= i_cfg_data;
                CFG_SEEK_GAIN:     r_seek_gain     <= i_cfg_data;
                CFG_FLEE_GAIN:     r_flee_gain     <= i_cfg_data;
                CFG_FLEE_RADIUS:   r_flee_radius   <= i_cfg_data;
                CFG_LOOKAHEAD:     r_lookahead     <= i_cfg_data;
                CFG_PURSUE_RADIUS: r_pursue_radius <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid chain outside the normalisers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r5_v    <= 1'b0;
            r6_v    <= 1'b0;
            r7_v    <= 1'b0;
            r8_v    <= 1'b0;
            r9_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r1_v    <= start && !busy;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= na_v;
            r5_v    <= r4_v;
            r6_v    <= r5_v;
            r7_v    <= nb_v;
            r8_v    <= r7_v;
            r9_v    <= r8_v;
            r_out_v <= r9_v;
        end
    end

    // Capture the input beat
    always_ff @(posedge i_clk) begin
        r1_ctx.cmd <= i_cmd;
        r1_ctx.ax  <= i_agent_pos_x;
        r1_ctx.ay  <= i_agent_pos_y;
        r1_ctx.vx  <= i_agent_vel_x;
        r1_ctx.vy  <= i_agent_vel_y;
        r1_ctx.tx  <= i_target_pos_x;
        r1_ctx.ty  <= i_target_pos_y;
        r1_ctx.px  <= i_target_pos_x;
        r1_ctx.py  <= i_target_pos_y;
        r1_ctx.eng <= 1'b0;
        r1_wx      <= i_target_vel_x;
        r1_wy      <= i_target_vel_y;
    end

    // Predicted target position
    sfu_mulq u_mul_la_x (.i_clk(i_clk), .i_a(r1_wx), .i_b(r_lookahead), .o_p(la_x));
    sfu_mulq u_mul_la_y (.i_clk(i_clk), .i_a(r1_wy), .i_b(r_lookahead), .o_p(la_y));

    always_comb begin
        n3_ctx    = r2_ctx;
        n3_ctx.px = sat_word(sx2(r2_ctx.tx) + sx2(la_x));
        n3_ctx.py = sat_word(sx2(r2_ctx.ty) + sx2(la_y));
    end

    always_ff @(posedge i_clk) begin
        r2_ctx <= r1_ctx;
        r3_ctx <= n3_ctx;
    end

    // Unit vector towards the current target position
    sfu_norm u_norm_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_v),
        .i_dx    (sx1(r3_ctx.tx) - sx1(r3_ctx.ax)),
        .i_dy    (sx1(r3_ctx.ty) - sx1(r3_ctx.ay)),
        .i_ctx   (r3_ctx),
        .o_valid (na_v),
        .o_ux    (na_ux),
        .o_uy    (na_uy),
        .o_ctx   (na_ctx)
    );

    // Standoff offset for pursuit
    sfu_mulq u_mul_pur_x (
        .i_clk (i_clk),
        .i_a   ({{(DATA_WIDTH-UW){na_ux[UW-1]}}, na_ux}),
        .i_b   (r_pursue_radius),
        .o_p   (pur_x)
    );
    sfu_mulq u_mul_pur_y (
        .i_clk (i_clk),
        .i_a   ({{(DATA_WIDTH-UW){na_uy[UW-1]}}, na_uy}),
        .i_b   (r_pursue_radius),
        .o_p   (pur_y)
    );

    // Radius test, first pass: per-axis distances against the radius
    always_comb begin
        dtx = sx1(na_ctx.tx) - sx1(na_ctx.ax);
        dty = sx1(na_ctx.ty) - sx1(na_ctx.ay);
        dpx = sx1(na_ctx.px) - sx1(na_ctx.ax);
        dpy = sx1(na_ctx.py) - sx1(na_ctx.ay);
        ntx = -dtx;
        nty = -dty;
        npx = -dpx;
        npy = -dpy;
        mtx = dtx[DIFF_W-1] ? ntx[DATA_WIDTH-1:0] : dtx[DATA_WIDTH-1:0];
        mty = dty[DIFF_W-1] ? nty[DATA_WIDTH-1:0] : dty[DATA_WIDTH-1:0];
        mpx = dpx[DIFF_W-1] ? npx[DATA_WIDTH-1:0] : dpx[DATA_WIDTH-1:0];
        mpy = dpy[DIFF_W-1] ? npy[DATA_WIDTH-1:0] : dpy[DATA_WIDTH-1:0];
        rad_ext = {{(DATA_WIDTH-CFG_W){1'b0}}, r_flee_radius};
    end

    always_ff @(posedge i_clk) begin
        r4_ctx <= na_ctx;
        r4_mtx <= mtx[CFG_W-1:0];
        r4_mty <= mty[CFG_W-1:0];
        r4_mpx <= mpx[CFG_W-1:0];
        r4_mpy <= mpy[CFG_W-1:0];
        r4_okt <= (mtx <= rad_ext) && (mty <= rad_ext);
        r4_okp <= (mpx <= rad_ext) && (mpy <= rad_ext);
    end

    // Pick the aim point for the mode
    always_comb begin
        n5_ctx = r4_ctx;
        case (r4_ctx.cmd)
            CMD_PURSUIT: begin
                n5_ctx.px = sat_word(sx2(r4_ctx.tx) - sx2(pur_x));
                n5_ctx.py = sat_word(sx2(r4_ctx.ty) - sx2(pur_y));
            end
            CMD_INTERCEPT, CMD_EVADE: begin
                n5_ctx.px = r4_ctx.px;
                n5_ctx.py = r4_ctx.py;
            end
            default: begin
                n5_ctx.px = r4_ctx.tx;
                n5_ctx.py = r4_ctx.ty;
            end
        endcase
    end

    // Radius test, second pass: squares
    always_ff @(posedge i_clk) begin
        r5_ctx  <= n5_ctx;
        r5_okt  <= r4_okt;
        r5_okp  <= r4_okp;
        r5_sqtx <= {{CFG_W{1'b0}}, r4_mtx} * {{CFG_W{1'b0}}, r4_mtx};
        r5_sqty <= {{CFG_W{1'b0}}, r4_mty} * {{CFG_W{1'b0}}, r4_mty};
        r5_sqpx <= {{CFG_W{1'b0}}, r4_mpx} * {{CFG_W{1'b0}}, r4_mpx};
        r5_sqpy <= {{CFG_W{1'b0}}, r4_mpy} * {{CFG_W{1'b0}}, r4_mpy};
        r5_rr   <= {{CFG_W{1'b0}}, r_flee_radius} * {{CFG_W{1'b0}}, r_flee_radius};
    end

    // Radius test, final compare, and the engaged flag
    always_comb begin
        wt = r5_okt && (({1'b0, r5_sqtx} + {1'b0, r5_sqty}) <= {1'b0, r5_rr});
        wp = r5_okp && (({1'b0, r5_sqpx} + {1'b0, r5_sqpy}) <= {1'b0, r5_rr});
        n6_ctx = r5_ctx;
        case (r5_ctx.cmd)
            CMD_SEEK, CMD_INTERCEPT, CMD_PURSUIT: n6_ctx.eng = 1'b1;
            CMD_FLEE:                             n6_ctx.eng = wt;
            CMD_EVADE:                            n6_ctx.eng = wt && wp;
            default:                              n6_ctx.eng = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r6_ctx <= n6_ctx;
    end

    // Unit vector towards the aim point
    sfu_norm u_norm_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r6_v),
        .i_dx    (sx1(r6_ctx.px) - sx1(r6_ctx.ax)),
        .i_dy    (sx1(r6_ctx.py) - sx1(r6_ctx.ay)),
        .i_ctx   (r6_ctx),
        .o_valid (nb_v),
        .o_ux    (nb_ux),
        .o_uy    (nb_uy),
        .o_ctx   (nb_ctx)
    );

    // Desired velocity
    sfu_mulq u_mul_spd_x (
        .i_clk (i_clk),
        .i_a   ({{(DATA_WIDTH-UW){nb_ux[UW-1]}}, nb_ux}),
        .i_b   (r_max_speed),
        .o_p   (spd_x)
    );
    sfu_mulq u_mul_spd_y (
        .i_clk (i_clk),
        .i_a   ({{(DATA_WIDTH-UW){nb_uy[UW-1]}}, nb_uy}),
        .i_b   (r_max_speed),
        .o_p   (spd_y)
    );

    // Velocity error, turned around when moving away
    always_comb begin
        if ((r7_ctx.cmd == CMD_FLEE) || (r7_ctx.cmd == CMD_EVADE)) begin
            n8_dx = sat_word(-sx2(spd_x) - sx2(r7_ctx.vx));
            n8_dy = sat_word(-sx2(spd_y) - sx2(r7_ctx.vy));
        end else begin
            n8_dx = sat_word(sx2(spd_x) - sx2(r7_ctx.vx));
            n8_dy = sat_word(sx2(spd_y) - sx2(r7_ctx.vy));
        end
    end

    always_ff @(posedge i_clk) begin
        r7_ctx <= nb_ctx;
        r8_ctx <= r7_ctx;
        r8_dx  <= n8_dx;
        r8_dy  <= n8_dy;
        r9_ctx <= r8_ctx;
    end

    // Gain
    assign away8 = (r8_ctx.cmd == CMD_FLEE) || (r8_ctx.cmd == CMD_EVADE);
    assign gain8 = away8 ? r_flee_gain : r_seek_gain;

    sfu_mulq u_mul_g_x (.i_clk(i_clk), .i_a(r8_dx), .i_b(gain8), .o_p(g_x));
    sfu_mulq u_mul_g_y (.i_clk(i_clk), .i_a(r8_dy), .i_b(gain8), .o_p(g_y));

    // Output register: drop the force when not engaged
    always_ff @(posedge i_clk) begin
        r_fx  <= r9_ctx.eng ? g_x : '0;
        r_fy  <= r9_ctx.eng ? g_y : '0;
        r_eng <= r9_ctx.eng;
    end

    assign o_valid   = r_out_v;
    assign o_force_x = r_fx;
    assign o_force_y = r_fy;
    assign o_engaged = r_eng;

    // Every result traces back to a beat accepted a fixed latency earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, SFU_LAT))
        else $error("result without matching command");

    // Normalised direction never exceeds unit length per axis
    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        nb_v |-> (nb_ux <= UNIT_POS) && (nb_ux >= UNIT_NEG) &&
                 (nb_uy <= UNIT_POS) && (nb_uy >= UNIT_NEG))
        else $error("normaliser output out of range");

    // Unused modes never engage
    a_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ($past(i_cmd, SFU_LAT) > CMD_EVADE) |-> !o_engaged)
        else $error("unused mode engaged");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import sfu_pkg::*;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        t_word ax, ay, vx, vy, tx, ty, wx, wy;
    } t_agent_beat;

    typedef struct packed {
        t_word fx;
        t_word fy;
        logic  eng;
    } t_force;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;
    localparam int     WATCHDOG_LIMIT = 5000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic o_valid, o_engaged;
    t_word o_force_x, o_force_y;
    t_agent_beat cur = '0;

    t_agent_beat beats_q[$];
    t_force      force_q[$];
    longint unsigned regs[0:5];
    int  gap = 0;
    bit  no_idle = 1'b0;
    int  errors = 0;
    int  beats_sent = 0;
    int  forces_seen = 0;
    int  engaged_seen = 0;
    int  quiet = 0;

    always #10 i_clk = ~i_clk;

    steering_force_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(cur.cmd),
        .i_agent_pos_x(cur.ax), .i_agent_pos_y(cur.ay),
        .i_agent_vel_x(cur.vx), .i_agent_vel_y(cur.vy),
        .i_target_pos_x(cur.tx), .i_target_pos_y(cur.ty),
        .i_target_vel_x(cur.wx), .i_target_vel_y(cur.wy),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_force_x(o_force_x), .o_force_y(o_force_y),
        .o_engaged(o_engaged)
    );

    // ---------------- fixed-point predictor ----------------

    function automatic longint sat_word_l(input longint v);
        if (v > WORD_MAX) return WORD_MAX;
        if (v < WORD_MIN) return WORD_MIN;
        return v;
    endfunction

    function automatic longint unsigned abs_l(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // Sign-magnitude Q16.16 product, truncated, saturated
    function automatic longint fx_mul(input longint a, input longint unsigned b);
        longint unsigned m, hi, lo, r;
        m  = abs_l(a);
        hi = (m >> 24) * b;
        lo = ((m & 64'hFF_FFFF) * b) >> FRAC_BITS;
        if (hi > (64'd1 << 23)) r = (64'd1 << 31) + 1;
        else r = (hi << 8) + lo;
        return sat_word_l((a < 0) ? -$signed(r) : $signed(r));
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, pw;
        res = 0;
        pw  = 64'd1 << 62;
        while (pw > v) pw >>= 2;
        while (pw != 0) begin
            if (v >= res + pw) begin
                v   = v - (res + pw);
                res = (res >> 1) + pw;
            end else begin
                res >>= 1;
            end
            pw >>= 2;
        end
        return res;
    endfunction

    // Unit vector in Q16.16; a zero direction gives zero
    task automatic unit_dir(input longint dx, input longint dy,
                            output longint ux, output longint uy);
        longint unsigned mx, my, len, qx, qy;
        mx = abs_l(dx);
        my = abs_l(dy);
        while (mx >= (64'd1 << 30) || my >= (64'd1 << 30)) begin
            mx >>= 1;
            my >>= 1;
        end
        len = int_sqrt(mx * mx + my * my);
        if (len == 0) begin
            ux = 0;
            uy = 0;
        end else begin
            qx = (mx << FRAC_BITS) / len;
            qy = (my << FRAC_BITS) / len;
            ux = (dx < 0) ? -$signed(qx) : $signed(qx);
            uy = (dy < 0) ? -$signed(qy) : $signed(qy);
        end
    endtask

    function automatic bit in_radius(input longint ax, input longint ay, input longint bx,
                                     input longint by, input longint unsigned r);
        longint unsigned mx, my;
        mx = abs_l(bx - ax);
        my = abs_l(by - ay);
        if (mx > r || my > r) return 1'b0;
        return (mx * mx + my * my) <= r * r;
    endfunction

    task automatic steer_to(input t_agent_beat b, input longint px, input longint py,
                            input longint unsigned gain, input bit away,
                            output longint fx, output longint fy);
        longint ux, uy, dx, dy;
        unit_dir(px - longint'(b.ax), py - longint'(b.ay), ux, uy);
        dx = fx_mul(ux, regs[CFG_MAX_SPEED]);
        dy = fx_mul(uy, regs[CFG_MAX_SPEED]);
        if (away) begin
            dx = -dx;
            dy = -dy;
        end
        fx = fx_mul(sat_word_l(dx - longint'(b.vx)), gain);
        fy = fx_mul(sat_word_l(dy - longint'(b.vy)), gain);
    endtask

    task automatic predict_force(input t_agent_beat b, output t_force f);
        longint ax, ay, tx, ty, fx, fy, px, py, ux, uy;
        bit eng;
        ax = b.ax; ay = b.ay; tx = b.tx; ty = b.ty;
        fx = 0; fy = 0; eng = 1'b0;
        // Predicted target position for intercept and evade
        px = sat_word_l(tx + fx_mul(longint'(b.wx), regs[CFG_LOOKAHEAD]));
        py = sat_word_l(ty + fx_mul(longint'(b.wy), regs[CFG_LOOKAHEAD]));
        case (b.cmd)
            CMD_SEEK: begin
                steer_to(b, tx, ty, regs[CFG_SEEK_GAIN], 1'b0, fx, fy);
                eng = 1'b1;
            end
            CMD_FLEE: begin
                eng = in_radius(ax, ay, tx, ty, regs[CFG_FLEE_RADIUS]);
                if (eng) steer_to(b, tx, ty, regs[CFG_FLEE_GAIN], 1'b1, fx, fy);
            end
            CMD_INTERCEPT: begin
                steer_to(b, px, py, regs[CFG_SEEK_GAIN], 1'b0, fx, fy);
                eng = 1'b1;
            end
            CMD_PURSUIT: begin
                unit_dir(tx - ax, ty - ay, ux, uy);
                px = sat_word_l(tx - fx_mul(ux, regs[CFG_PURSUE_RADIUS]));
                py = sat_word_l(ty - fx_mul(uy, regs[CFG_PURSUE_RADIUS]));
                steer_to(b, px, py, regs[CFG_SEEK_GAIN], 1'b0, fx, fy);
                eng = 1'b1;
            end
            CMD_EVADE: begin
                eng = in_radius(ax, ay, px, py, regs[CFG_FLEE_RADIUS]) &&
                      in_radius(ax, ay, tx, ty, regs[CFG_FLEE_RADIUS]);
                if (eng) steer_to(b, px, py, regs[CFG_FLEE_GAIN], 1'b1, fx, fy);
            end
            default: ;
        endcase
        f.fx  = t_word'(sat_word_l(fx));
        f.fy  = t_word'(sat_word_l(fy));
        f.eng = eng;
    endtask

    // ---------------- stimulus helpers ----------------

    function automatic t_word rnd_word(input int kind);
        case (kind)
            0: return t_word'($urandom);
            1: return t_word'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
            2: return t_word'($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
            default: return t_word'($signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000);
        endcase
    endfunction

    // Mostly close pairs so that the flee and evade radii are hit often
    function automatic t_agent_beat rnd_beat();
        t_agent_beat b;
        int kind;
        kind  = $urandom_range(0, 9);
        b.cmd = ($urandom_range(0, 15) == 0) ? CMD_W'($urandom_range(5, 7))
                                             : CMD_W'($urandom_range(0, 4));
        if (kind < 6) begin
            b.ax = rnd_word(3);
            b.ay = rnd_word(3);
            b.tx = b.ax + rnd_word(1);
            b.ty = b.ay + rnd_word(1);
            b.vx = rnd_word(1);
            b.vy = rnd_word(1);
            b.wx = rnd_word(1);
            b.wy = rnd_word(1);
        end else begin
            b.ax = rnd_word(kind == 9 ? 2 : 0);
            b.ay = rnd_word(0);
            b.tx = rnd_word(kind == 9 ? 2 : 0);
            b.ty = rnd_word(0);
            b.vx = rnd_word(kind == 8 ? 2 : 0);
            b.vy = rnd_word(0);
            b.wx = rnd_word(0);
            b.wy = rnd_word(kind == 8 ? 2 : 0);
        end
        return b;
    endfunction

    function automatic t_agent_beat mk_beat(input logic [CMD_W-1:0] c,
            input t_word ax, input t_word ay, input t_word vx, input t_word vy,
            input t_word tx, input t_word ty, input t_word wx, input t_word wy);
        t_agent_beat b;
        b.cmd = c; b.ax = ax; b.ay = ay; b.vx = vx; b.vy = vy;
        b.tx = tx; b.ty = ty; b.wx = wx; b.wy = wy;
        return b;
    endfunction

    // Wait for the pipeline to drain completely
    task automatic drain();
        while (beats_q.size() != 0 || start || force_q.size() != 0) @(posedge i_clk);
        repeat (SFU_LAT + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx <= CFG_PURSUE_RADIUS) regs[idx] = val;
    endtask

    task automatic write_all(input logic [CFG_W-1:0] ms, input logic [CFG_W-1:0] sg,
                             input logic [CFG_W-1:0] fg, input logic [CFG_W-1:0] fr,
                             input logic [CFG_W-1:0] la, input logic [CFG_W-1:0] pr);
        write_reg(CFG_MAX_SPEED, ms);
        write_reg(CFG_SEEK_GAIN, sg);
        write_reg(CFG_FLEE_GAIN, fg);
        write_reg(CFG_FLEE_RADIUS, fr);
        write_reg(CFG_LOOKAHEAD, la);
        write_reg(CFG_PURSUE_RADIUS, pr);
    endtask

    function automatic logic [CFG_W-1:0] rnd_cfg();
        case ($urandom_range(0, 3))
            0: return CFG_W'($urandom);
            1: return CFG_W'($urandom_range(0, 32'h0040_0000));
            default: return CFG_W'($urandom_range(32'h0000_4000, 32'h0080_0000));
        endcase
    endfunction

    // ---------------- sequence ----------------

    initial begin
        t_word big, neg;
        big = 32'sh7FFF_FFFF;
        neg = 32'sh8000_0000;
        regs[CFG_MAX_SPEED]     = RST_MAX_SPEED;
        regs[CFG_SEEK_GAIN]     = RST_SEEK_GAIN;
        regs[CFG_FLEE_GAIN]     = RST_FLEE_GAIN;
        regs[CFG_FLEE_RADIUS]   = RST_FLEE_RADIUS;
        regs[CFG_LOOKAHEAD]     = RST_LOOKAHEAD;
        regs[CFG_PURSUE_RADIUS] = RST_PURSUE_RADIUS;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats at reset settings
        for (int c = 0; c < 8; c++) begin
            // zero direction: agent on top of target
            beats_q.push_back(mk_beat(CMD_W'(c), 32'sh10000, -32'sh20000, 32'sh30000,
                                      32'sh0, 32'sh10000, -32'sh20000, 32'sh0, 32'sh0));
            // opposite corners of the number range
            beats_q.push_back(mk_beat(CMD_W'(c), neg, neg, big, neg, big, big, big, big));
        end
        // flee out of radius, and just on the radius edge
        beats_q.push_back(mk_beat(CMD_FLEE, 0, 0, 0, 0, 32'sh0064_0001, 0, 0, 0));
        beats_q.push_back(mk_beat(CMD_FLEE, 0, 0, 0, 0, 32'sh0064_0000, 0, 0, 0));
        // evade: current inside, predicted outside, then both inside
        beats_q.push_back(mk_beat(CMD_EVADE, 0, 0, 0, 0, 32'sh000A_0000, 0,
                                  32'sh00C8_0000, 0));
        beats_q.push_back(mk_beat(CMD_EVADE, 0, 0, 32'sh0001_0000, 0, 32'sh000A_0000,
                                  32'sh0005_0000, -32'sh0002_0000, 32'sh0001_0000));
        // pursuit closer than the standoff, and an intercept far away
        beats_q.push_back(mk_beat(CMD_PURSUIT, 0, 0, 0, 0, 32'sh0001_0000, 0, 0, 0));
        beats_q.push_back(mk_beat(CMD_INTERCEPT, 0, 0, neg, big, neg, big, neg, neg));
        for (int i = 0; i < 160; i++) beats_q.push_back(rnd_beat());
        drain();

        // Extremes, random settings, then moderate settings without idling
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_all('0, '0, '0, '0, '0, '0);
                1: write_all('1, '1, '1, '1, '1, '1);
                2: write_all(31'h0001_0000, 31'h0000_8000, 31'h0002_0000, '1, 31'h0000_0100, '0);
                3, 4: write_all(rnd_cfg(), rnd_cfg(), rnd_cfg(), rnd_cfg(), rnd_cfg(), rnd_cfg());
                default: begin
                    write_reg(IDX_W'(7), '1);
                    write_all(31'h0020_0000, 31'h0001_8000, 31'h0000_C000, 31'h0100_0000,
                              31'h0002_0000, 31'h0010_0000);
                    no_idle = 1'b1;
                end
            endcase
            for (int i = 0; i < 165; i++) beats_q.push_back(rnd_beat());
            drain();
        end

        $display("Covered %0d beats (%0d engaged) over seven register settings,",
                 beats_sent, engaged_seen);
        $display("all five modes plus unused codes, extremes and random idle bursts.");
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Driver: present one beat per start, idle in random bursts
    always @(posedge i_clk) begin
        logic go;
        go = 1'b0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                t_force f;
                predict_force(cur, f);
                force_q.push_back(f);
                beats_sent++;
            end
            if (start && busy) begin
                go = 1'b1;
            end else if (gap > 0) begin
                gap--;
            end else if (beats_q.size() != 0) begin
                cur <= beats_q.pop_front();
                go = 1'b1;
                if (!no_idle && $urandom_range(0, 11) == 0) gap = $urandom_range(1, 19);
            end
            start <= go;
        end
    end

    // Monitor: check each result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_force e;
        if (i_rst_n && o_valid) begin
            forces_seen++;
            if (force_q.size() == 0) begin
                $display("%0t: unexpected result fx=%0d fy=%0d eng=%0b", $time,
                         o_force_x, o_force_y, o_engaged);
                errors++;
            end else begin
                e = force_q.pop_front();
                if (o_engaged) engaged_seen++;
                if (o_force_x !== e.fx) begin
                    $display("%0t: force_x expected %0d got %0d", $time, e.fx, o_force_x);
                    errors++;
                end
                if (o_force_y !== e.fy) begin
                    $display("%0t: force_y expected %0d got %0d", $time, e.fy, o_force_y);
                    errors++;
                end
                if (o_engaged !== e.eng) begin
                    $display("%0t: engaged expected %0b got %0b", $time, e.eng, o_engaged);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, force_q.size());
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

endmodule
